FILE: rtl/pmm_pkg.sv
// Shared types, codes and constants of the polymer Metropolis move unit.
package pmm_pkg;

  typedef logic signed [23:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  typedef struct packed {
    logic [23:0] k;
    logic [23:0] rest;
    logic [23:0] sigma;
    logic [23:0] eps;
  } eu_cfg_t;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] CFG_K     = 2'd0;
  localparam logic [1:0] CFG_REST  = 2'd1;
  localparam logic [1:0] CFG_SIGMA = 2'd2;
  localparam logic [1:0] CFG_EPS   = 2'd3;

  localparam int DIFF_W = 49;
  localparam logic signed [63:0] DE_MAX = 64'sd549755813887;
  localparam logic signed [63:0] DE_MIN = -64'sd549755813888;
  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = -24'sh800000;
  localparam logic [19:0] U_CAP = 20'h80000;

  typedef enum logic [3:0] {
    T_IDLE, T_SEEK, T_SHIFT, T_CHECK, T_WAIT, T_EXP, T_EXPW, T_DONE
  } top_state_t;

  typedef enum logic [4:0] {
    E_IDLE, E_SIG, E_SQX, E_SQY, E_SQZ, E_SUM, E_SEL, E_SQRT, E_DEV, E_KMUL,
    E_BTERM, E_DIV, E_U2, E_U3, E_U6, E_E6, E_E3, E_PTERM, E_FIN
  } eu_state_t;

  // exp(-2^(k-16)) in Q.31
  function automatic logic [30:0] exp_tab(input logic [4:0] k);
    logic [30:0] t;
    case (k)
      5'd0:  t = 31'd2147450880;
      5'd1:  t = 31'd2147418113;
      5'd2:  t = 31'd2147352580;
      5'd3:  t = 31'd2147221520;
      5'd4:  t = 31'd2146959424;
      5'd5:  t = 31'd2146435328;
      5'd6:  t = 31'd2145387520;
      5'd7:  t = 31'd2143293437;
      5'd8:  t = 31'd2139111403;
      5'd9:  t = 31'd2130771798;
      5'd10: t = 31'd2114190000;
      5'd11: t = 31'd2081412522;
      5'd12: t = 31'd2017374191;
      5'd13: t = 31'd1895147668;
      5'd14: t = 31'd1672461947;
      5'd15: t = 31'd1302514674;
      5'd16: t = 31'd790015084;
      5'd17: t = 31'd290630308;
      5'd18: t = 31'd39332535;
      5'd19: t = 31'd720401;
      default: t = 31'd0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/pmm_bead_cell.sv
// One bead cell of the position ring: holds a bead and passes it to its neighbor.
module pmm_bead_cell #(
  parameter logic [23:0] INIT_Z = 24'd0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          load,
  input  pmm_pkg::pos_t load_pos,
  input  pmm_pkg::pos_t in_pos,
  output pmm_pkg::pos_t pos
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos.x <= '0;
      pos.y <= '0;
      pos.z <= INIT_Z;
    end else if (shift) begin
      pos <= in_pos;
    end else if (load) begin
      pos <= load_pos;
    end
  end

endmodule

FILE: rtl/pmm_energy_unit.sv
// Sequential evaluator of one pair term (bond or repulsion) for new and old positions.
module pmm_energy_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               is_bond,
  input  pmm_pkg::eu_cfg_t                   cfg,
  input  pmm_pkg::pos_t                      head,
  input  pmm_pkg::pos_t                      new_pos,
  input  pmm_pkg::pos_t                      old_pos,
  output logic                               busy,
  output logic                               done,
  output logic signed [pmm_pkg::DIFF_W-1:0]  diff
);

  localparam int DIFF_W = pmm_pkg::DIFF_W;

  pmm_pkg::eu_state_t st, st_next;

  logic        phase;
  logic [47:0] s2;
  logic [49:0] d2;
  logic [49:0] v, r, bitv;
  logic [49:0] rem;
  logic [18:0] nb;
  logic [18:0] q;
  logic [4:0]  cnt;
  logic [19:0] u;
  logic [25:0] u3;
  logic [45:0] e6;
  logic signed [47:0] term, first;
  logic [61:0] prod;

  logic [35:0] mul_a;
  logic [25:0] mul_b;
  pmm_pkg::pos_t p;
  logic signed [24:0] dx, dy, dz;
  logic [24:0] ax, ay, az;
  logic [25:0] len, dev;
  logic [25:0] e4;
  logic [50:0] sq_sum;
  logic [50:0] rem2;
  logic [18:0] q_next;

  assign p  = phase ? old_pos : new_pos;
  assign dx = {head.x[23], head.x} - {p.x[23], p.x};
  assign dy = {head.y[23], head.y} - {p.y[23], p.y};
  assign dz = {head.z[23], head.z} - {p.z[23], p.z};
  assign ax = dx[24] ? 25'(-dx) : 25'(dx);
  assign ay = dy[24] ? 25'(-dy) : 25'(dy);
  assign az = dz[24] ? 25'(-dz) : 25'(dz);
  assign len = r[25:0];
  assign dev = (len >= 26'(cfg.rest)) ? len - 26'(cfg.rest) : 26'(cfg.rest) - len;
  assign e4 = {cfg.eps, 2'b00};
  assign sq_sum = {1'b0, r} + {1'b0, bitv};
  assign rem2 = {rem, nb[18]};
  assign q_next = (rem2 >= {1'b0, d2}) ? {q[17:0], 1'b1} : {q[17:0], 1'b0};
  assign busy = (st != pmm_pkg::E_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      pmm_pkg::E_SIG:  begin mul_a = 36'(cfg.sigma); mul_b = 26'(cfg.sigma); end
      pmm_pkg::E_SQX:  begin mul_a = 36'(ax); mul_b = 26'(ax); end
      pmm_pkg::E_SQY:  begin mul_a = 36'(ay); mul_b = 26'(ay); end
      pmm_pkg::E_SQZ:  begin mul_a = 36'(az); mul_b = 26'(az); end
      pmm_pkg::E_DEV:  begin mul_a = 36'(dev); mul_b = dev; end
      pmm_pkg::E_KMUL: begin mul_a = prod[51:16]; mul_b = 26'(cfg.k); end
      pmm_pkg::E_U2:   begin mul_a = 36'(u); mul_b = 26'(u); end
      pmm_pkg::E_U3:   begin mul_a = 36'(prod[38:16]); mul_b = 26'(u); end
      pmm_pkg::E_U6:   begin mul_a = 36'(prod[41:16]); mul_b = prod[41:16]; end
      pmm_pkg::E_E6:   begin mul_a = prod[51:16]; mul_b = e4; end
      pmm_pkg::E_E3:   begin mul_a = 36'(u3); mul_b = e4; end
      default: ;
    endcase
  end

  always_comb begin
    st_next = st;
    unique case (st)
      pmm_pkg::E_IDLE:  if (start) st_next = pmm_pkg::E_SIG;
      pmm_pkg::E_SIG:   st_next = pmm_pkg::E_SQX;
      pmm_pkg::E_SQX:   st_next = pmm_pkg::E_SQY;
      pmm_pkg::E_SQY:   st_next = pmm_pkg::E_SQZ;
      pmm_pkg::E_SQZ:   st_next = pmm_pkg::E_SUM;
      pmm_pkg::E_SUM:   st_next = pmm_pkg::E_SEL;
      pmm_pkg::E_SEL: begin
        if (is_bond) st_next = pmm_pkg::E_SQRT;
        else if (({2'b0, d2} >= {s2, 4'b0}) || (cfg.eps == '0)) st_next = pmm_pkg::E_FIN;
        else if ((d2 == '0) || ({5'b0, s2} >= {d2, 3'b0})) st_next = pmm_pkg::E_U2;
        else st_next = pmm_pkg::E_DIV;
      end
      pmm_pkg::E_SQRT:  if (bitv[0]) st_next = pmm_pkg::E_DEV;
      pmm_pkg::E_DEV:   st_next = pmm_pkg::E_KMUL;
      pmm_pkg::E_KMUL:  st_next = pmm_pkg::E_BTERM;
      pmm_pkg::E_BTERM: st_next = pmm_pkg::E_FIN;
      pmm_pkg::E_DIV:   if (cnt == 5'd18) st_next = pmm_pkg::E_U2;
      pmm_pkg::E_U2:    st_next = pmm_pkg::E_U3;
      pmm_pkg::E_U3:    st_next = pmm_pkg::E_U6;
      pmm_pkg::E_U6:    st_next = pmm_pkg::E_E6;
      pmm_pkg::E_E6:    st_next = pmm_pkg::E_E3;
      pmm_pkg::E_E3:    st_next = pmm_pkg::E_PTERM;
      pmm_pkg::E_PTERM: st_next = pmm_pkg::E_FIN;
      pmm_pkg::E_FIN:   st_next = phase ? pmm_pkg::E_IDLE : pmm_pkg::E_SQX;
      default:          st_next = pmm_pkg::E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= pmm_pkg::E_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= (st == pmm_pkg::E_FIN) && phase;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 62'(mul_a * mul_b);
    case (st)
      pmm_pkg::E_IDLE: phase <= 1'b0;
      pmm_pkg::E_SQX:  if (!phase) s2 <= prod[47:0];
      pmm_pkg::E_SQY:  d2 <= prod[49:0];
      pmm_pkg::E_SQZ:  d2 <= d2 + prod[49:0];
      pmm_pkg::E_SUM:  d2 <= d2 + prod[49:0];
      pmm_pkg::E_SEL: begin
        term <= '0;
        v    <= d2;
        r    <= '0;
        bitv <= 50'(1) << 48;
        u    <= pmm_pkg::U_CAP;
        rem  <= 50'(s2[47:3]);
        nb   <= {s2[2:0], 16'b0};
        q    <= '0;
        cnt  <= '0;
      end
      pmm_pkg::E_SQRT: begin
        if ({1'b0, v} >= sq_sum) begin
          v <= v - sq_sum[49:0];
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
      end
      pmm_pkg::E_BTERM: term <= 48'(prod[61:17]);
      pmm_pkg::E_DIV: begin
        rem <= (rem2 >= {1'b0, d2}) ? 50'(rem2 - {1'b0, d2}) : rem2[49:0];
        q   <= q_next;
        nb  <= {nb[17:0], 1'b0};
        cnt <= cnt + 5'd1;
        u   <= {1'b0, q_next};
      end
      pmm_pkg::E_U6:  u3 <= prod[41:16];
      pmm_pkg::E_E3:  e6 <= prod[61:16];
      pmm_pkg::E_PTERM: term <= $signed({2'b0, e6}) - $signed({2'b0, prod[61:16]});
      pmm_pkg::E_FIN: begin
        if (!phase) begin
          first <= term;
          phase <= 1'b1;
        end else begin
          diff <= DIFF_W'(first) - DIFF_W'(term);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/pmm_exp_unit.sv
// Bit-serial exp(-dE) evaluator: one table product per step over twenty steps.
module pmm_exp_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] d,
  output logic        busy,
  output logic        done,
  output logic [31:0] ex
);

  logic [19:0] dr;
  logic [4:0]  cnt;
  logic [62:0] prod;

  assign prod = 63'(ex * pmm_pkg::exp_tab(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd19) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ex  <= 32'h8000_0000;
      dr  <= d;
      cnt <= '0;
    end else if (busy) begin
      if (dr[0]) ex <= prod[62:31];
      dr  <= dr >> 1;
      cnt <= cnt + 5'd1;
    end
  end

endmodule

FILE: rtl/polymer_metropolis_move_unit.sv
// Top level: bead ring, move controller, energy and acceptance units.
// Load/read: the ring rotates until the addressed bead is at the head, then the item finishes.
// Move: after the same seek, each other bead gets one pair evaluation (a short path with repulsion off
// or outside the cutoff, a capped path, a divide inside the cutoff, a square root for a bonded neighbor).
// Then acceptance. One item at a time: a new item is taken only in idle, once the last is in the output register.
// Reset (synchronous): beads return to x=y=0, z=index*65536 (saturated), registers to defaults, no sweep.
module polymer_metropolis_move_unit #(
  parameter int BEAD_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [4:0]          bead_index,
  input  logic signed [23:0]  x_value,
  input  logic signed [23:0]  y_value,
  input  logic signed [23:0]  z_value,
  input  logic [15:0]         uniform_draw,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                accepted,
  output logic signed [39:0]  delta_energy,
  output logic signed [23:0]  pos_x,
  output logic signed [23:0]  pos_y,
  output logic signed [23:0]  pos_z
);

  localparam int IW    = $clog2(BEAD_COUNT);
  localparam int XW    = ((IW > 5) ? IW : 5) + 1;
  localparam int ACC_W = pmm_pkg::DIFF_W + IW + 1;
  localparam logic signed [ACC_W-1:0] DE_HI = ACC_W'(pmm_pkg::DE_MAX);
  localparam logic signed [ACC_W-1:0] DE_LO = ACC_W'(pmm_pkg::DE_MIN);

  pmm_pkg::top_state_t state, state_next;

  // configuration registers
  pmm_pkg::eu_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.k     <= 24'd655360;
      cfg.rest  <= 24'd65536;
      cfg.sigma <= 24'd65536;
      cfg.eps   <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmm_pkg::CFG_K:     cfg.k     <= cfg_data;
        pmm_pkg::CFG_REST:  cfg.rest  <= cfg_data;
        pmm_pkg::CFG_SIGMA: cfg.sigma <= cfg_data;
        pmm_pkg::CFG_EPS:   cfg.eps   <= cfg_data;
        default: ;
      endcase
    end
  end

  // bead ring: cell 0 is the head, every shift advances the head by one bead
  pmm_pkg::pos_t ring [BEAD_COUNT];
  pmm_pkg::pos_t head, load_pos;
  logic ring_shift, ring_load;
  logic [IW-1:0] head_idx;

  assign head = ring[0];

  for (genvar g = 0; g < BEAD_COUNT; g++) begin : g_cell
    localparam int ZI = (g * 65536 > 8388607) ? 8388607 : g * 65536;
    pmm_bead_cell #(.INIT_Z(24'(ZI))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ring_shift),
      .load     ((g == 0) && ring_load),
      .load_pos (load_pos),
      .in_pos   (ring[(g + 1) % BEAD_COUNT]),
      .pos      (ring[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else if (ring_shift) begin
      head_idx <= (head_idx == IW'(BEAD_COUNT - 1)) ? '0 : head_idx + 1'b1;
    end
  end

  // latched item
  logic [1:0]    mode_r;
  logic [IW-1:0] tgt;
  pmm_pkg::pos_t val, oldp, newp, sat_pos;
  logic [15:0]   draw;
  logic signed [ACC_W-1:0] acc;
  logic signed [39:0] de_sat;
  logic          in_bad, at_tgt, is_bond, de_small, rej0, rej1;

  // result waiting for the output register
  logic          res_acc;
  logic signed [39:0] res_de;
  pmm_pkg::pos_t res_pos;

  logic eu_start, eu_busy, eu_done;
  logic signed [pmm_pkg::DIFF_W-1:0] eu_diff;
  logic exp_start, exp_busy, exp_done;
  logic [31:0] ex;

  function automatic pmm_pkg::coord_t sat_add(pmm_pkg::coord_t a, pmm_pkg::coord_t b);
    logic signed [24:0] s;
    s = {a[23], a} + {b[23], b};
    if (s[24] != s[23]) return s[24] ? pmm_pkg::COORD_MIN : pmm_pkg::COORD_MAX;
    return s[23:0];
  endfunction

  assign sat_pos.x = sat_add(head.x, val.x);
  assign sat_pos.y = sat_add(head.y, val.y);
  assign sat_pos.z = sat_add(head.z, val.z);

  assign in_bad = !((mode == pmm_pkg::MODE_LOAD) || (mode == pmm_pkg::MODE_MOVE) ||
                    (mode == pmm_pkg::MODE_READ)) ||
                  (XW'(bead_index) >= XW'(BEAD_COUNT));
  assign at_tgt = (head_idx == tgt);
  assign is_bond = ((IW + 1)'(head_idx) == (IW + 1)'(tgt) + 1'b1) ||
                   ((IW + 1)'(tgt) == (IW + 1)'(head_idx) + 1'b1);

  always_comb begin
    if (acc > DE_HI) de_sat = 40'(pmm_pkg::DE_MAX);
    else if (acc < DE_LO) de_sat = 40'(pmm_pkg::DE_MIN);
    else de_sat = acc[39:0];
  end

  // positive and below 16.0: run the exp table; larger dE has exp = 0
  assign de_small = !de_sat[39] && (de_sat != '0) && (de_sat[39:20] == '0);
  assign rej0 = !de_sat[39] && (de_sat != '0) && (draw != '0);
  assign rej1 = ex < {1'b0, draw, 15'b0};

  assign load_pos = (state == pmm_pkg::T_SEEK) ? val : newp;

  always_ff @(posedge clk) begin
    if (rst) state <= pmm_pkg::T_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ring_shift = 1'b0;
    ring_load  = 1'b0;
    eu_start   = 1'b0;
    exp_start  = 1'b0;
    unique case (state)
      pmm_pkg::T_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = in_bad ? pmm_pkg::T_DONE : pmm_pkg::T_SEEK;
      end
      pmm_pkg::T_SEEK: begin
        if (at_tgt) begin
          unique case (mode_r)
            pmm_pkg::MODE_LOAD: begin
              ring_load  = 1'b1;
              state_next = pmm_pkg::T_DONE;
            end
            pmm_pkg::MODE_MOVE: state_next = pmm_pkg::T_SHIFT;
            default:            state_next = pmm_pkg::T_DONE;
          endcase
        end else begin
          ring_shift = 1'b1;
        end
      end
      pmm_pkg::T_SHIFT: begin
        ring_shift = 1'b1;
        state_next = pmm_pkg::T_CHECK;
      end
      pmm_pkg::T_CHECK: begin
        // back at the moved bead once the ring has turned fully
        if (at_tgt) begin
          state_next = pmm_pkg::T_EXP;
        end else begin
          eu_start   = 1'b1;
          state_next = pmm_pkg::T_WAIT;
        end
      end
      pmm_pkg::T_WAIT: if (eu_done) state_next = pmm_pkg::T_SHIFT;
      pmm_pkg::T_EXP: begin
        if (de_small) begin
          exp_start  = 1'b1;
          state_next = pmm_pkg::T_EXPW;
        end else begin
          ring_load  = !rej0;
          state_next = pmm_pkg::T_DONE;
        end
      end
      pmm_pkg::T_EXPW: begin
        if (exp_done) begin
          ring_load  = !rej1;
          state_next = pmm_pkg::T_DONE;
        end
      end
      pmm_pkg::T_DONE: if (!out_valid || out_ready) state_next = pmm_pkg::T_IDLE;
      default: state_next = pmm_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      pmm_pkg::T_IDLE: begin
        if (in_valid) begin
          mode_r  <= mode;
          tgt     <= IW'(bead_index);
          val.x   <= x_value;
          val.y   <= y_value;
          val.z   <= z_value;
          draw    <= uniform_draw;
          res_acc <= 1'b0;
          res_de  <= '0;
          res_pos <= '0;
        end
      end
      pmm_pkg::T_SEEK: begin
        if (at_tgt) begin
          case (mode_r)
            pmm_pkg::MODE_LOAD: res_pos <= val;
            pmm_pkg::MODE_READ: res_pos <= head;
            default: begin
              oldp <= head;
              newp <= sat_pos;
              acc  <= '0;
            end
          endcase
        end
      end
      pmm_pkg::T_WAIT: if (eu_done) acc <= acc + ACC_W'(eu_diff);
      pmm_pkg::T_EXP: begin
        res_de <= de_sat;
        if (!de_small) begin
          res_acc <= !rej0;
          res_pos <= rej0 ? oldp : newp;
        end
      end
      pmm_pkg::T_EXPW: begin
        if (exp_done) begin
          res_acc <= !rej1;
          res_pos <= rej1 ? oldp : newp;
        end
      end
      default: ;
    endcase
  end

  // output register: holds a finished item while the next one is read in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pmm_pkg::T_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pmm_pkg::T_DONE && (!out_valid || out_ready)) begin
      accepted     <= res_acc;
      delta_energy <= res_de;
      pos_x        <= res_pos.x;
      pos_y        <= res_pos.y;
      pos_z        <= res_pos.z;
    end
  end

  pmm_energy_unit u_energy (
    .clk     (clk),
    .rst     (rst),
    .start   (eu_start),
    .is_bond (is_bond),
    .cfg     (cfg),
    .head    (head),
    .new_pos (newp),
    .old_pos (oldp),
    .busy    (eu_busy),
    .done    (eu_done),
    .diff    (eu_diff)
  );

  pmm_exp_unit u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .d     (de_sat[19:0]),
    .busy  (exp_busy),
    .done  (exp_done),
    .ex    (ex)
  );

  // the ring stays put while a pair term is being evaluated
  a_eu_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    eu_busy |-> (state == pmm_pkg::T_WAIT && !ring_shift))
    else $error("energy unit busy outside of pair evaluation");

  a_exp_only_in_expw: assert property (@(posedge clk) disable iff (rst)
    exp_busy |-> (state == pmm_pkg::T_EXPW))
    else $error("exp unit busy outside of acceptance step");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    (XW'(head_idx) < XW'(BEAD_COUNT)))
    else $error("ring head index out of range");

  a_downhill_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && delta_energy[39]) |-> accepted)
    else $error("energy-lowering move was rejected");

endmodule

FILE: tb/sv/polymer_metropolis_move_unit_tb.sv
// Self-checking testbench for the polymer Metropolis move unit: loads, reads and moves.
module polymer_metropolis_move_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBEAD = 32;
  localparam int N_RANDOM = 1930;
  localparam longint CYCLE_LIMIT = 64'd30000000;

  typedef struct packed {
    logic [1:0]      mode;
    logic [4:0]      idx;
    pmm_pkg::coord_t vx;
    pmm_pkg::coord_t vy;
    pmm_pkg::coord_t vz;
    logic [15:0]     draw;
  } move_req_t;

  typedef struct packed {
    logic               acc;
    logic signed [39:0] de;
    pmm_pkg::coord_t    px;
    pmm_pkg::coord_t    py;
    pmm_pkg::coord_t    pz;
  } move_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pmm_pkg::CFG_K;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = pmm_pkg::MODE_LOAD;
  logic [4:0] bead_index = '0;
  logic signed [23:0] x_value = '0, y_value = '0, z_value = '0;
  logic [15:0] uniform_draw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic signed [39:0] delta_energy;
  logic signed [23:0] pos_x, pos_y, pos_z;

  polymer_metropolis_move_unit #(.BEAD_COUNT(NBEAD)) dut (.*);

  always #10 clk = ~clk;

  // Predictor state: bead positions and the energy registers.
  pmm_pkg::coord_t chain_x [NBEAD];
  pmm_pkg::coord_t chain_y [NBEAD];
  pmm_pkg::coord_t chain_z [NBEAD];
  logic [63:0] k_q, rest_q, sigma_q, eps_q;

  move_req_t pending_items[$];
  move_rsp_t expected_results[$];
  int mismatches = 0;
  bit no_idle = 1'b0;
  bit timed_out = 1'b0;
  longint cycles = 0;

  localparam logic [30:0] EXP_TAB [20] = '{
    31'd2147450880, 31'd2147418113, 31'd2147352580, 31'd2147221520, 31'd2146959424,
    31'd2146435328, 31'd2145387520, 31'd2143293437, 31'd2139111403, 31'd2130771798,
    31'd2114190000, 31'd2081412522, 31'd2017374191, 31'd1895147668, 31'd1672461947,
    31'd1302514674, 31'd790015084, 31'd290630308, 31'd39332535, 31'd720401};

  function automatic pmm_pkg::coord_t clamp24(longint v);
    if (v > 64'sd8388607) return pmm_pkg::COORD_MAX;
    if (v < -64'sd8388608) return pmm_pkg::COORD_MIN;
    return pmm_pkg::coord_t'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sep2(pmm_pkg::coord_t ax, pmm_pkg::coord_t ay,
                                       pmm_pkg::coord_t az, int j);
    longint dx, dy, dz;
    dx = longint'(ax) - longint'(chain_x[j]);
    dy = longint'(ay) - longint'(chain_y[j]);
    dz = longint'(az) - longint'(chain_z[j]);
    return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
  endfunction

  function automatic longint spring_energy(logic [63:0] d2);
    logic [63:0] len, dev, dev2;
    len = int_sqrt(d2);
    dev = (len >= rest_q) ? len - rest_q : rest_q - len;
    dev2 = (dev * dev) >> 16;
    return longint'((k_q * dev2) >> 17);
  endfunction

  function automatic longint repulsion_energy(logic [63:0] d2);
    logic [63:0] s2, u, q, rem, u3, u6, e4;
    s2 = sigma_q * sigma_q;
    e4 = 4 * eps_q;
    if (d2 >= 16 * s2) return 0;
    if (d2 == 0) begin
      u = 64'(pmm_pkg::U_CAP);
    end else begin
      q = s2 / d2;
      if (q >= 8) begin
        u = 64'(pmm_pkg::U_CAP);
      end else begin
        rem = s2 % d2;
        for (int i = 0; i < 16; i++) begin
          rem <<= 1;
          q <<= 1;
          if (rem >= d2) begin
            rem -= d2;
            q |= 1;
          end
        end
        u = (q > 64'(pmm_pkg::U_CAP)) ? 64'(pmm_pkg::U_CAP) : q;
      end
    end
    u3 = (((u * u) >> 16) * u) >> 16;
    u6 = (u3 * u3) >> 16;
    return longint'((e4 * u6) >> 16) - longint'((e4 * u3) >> 16);
  endfunction

  function automatic longint site_energy(int b, pmm_pkg::coord_t px, pmm_pkg::coord_t py,
                                         pmm_pkg::coord_t pz);
    longint e;
    int gap;
    e = 0;
    for (int j = 0; j < NBEAD; j++) begin
      gap = (j > b) ? j - b : b - j;
      if (gap == 1) e += spring_energy(sep2(px, py, pz, j));
      else if (gap >= 2) e += repulsion_energy(sep2(px, py, pz, j));
    end
    return e;
  endfunction

  // Apply one item to the chain and return the result it should produce.
  function automatic move_rsp_t apply_move(move_req_t r);
    move_rsp_t o;
    pmm_pkg::coord_t nx, ny, nz;
    longint de;
    logic [63:0] ex;
    bit reject;
    int b;
    o = '0;
    if (r.mode != pmm_pkg::MODE_LOAD && r.mode != pmm_pkg::MODE_MOVE &&
        r.mode != pmm_pkg::MODE_READ) return o;
    if (int'(r.idx) >= NBEAD) return o;
    b = r.idx;
    de = 0;
    if (r.mode == pmm_pkg::MODE_LOAD) begin
      chain_x[b] = r.vx;
      chain_y[b] = r.vy;
      chain_z[b] = r.vz;
    end else if (r.mode == pmm_pkg::MODE_MOVE) begin
      nx = clamp24(longint'(chain_x[b]) + longint'(r.vx));
      ny = clamp24(longint'(chain_y[b]) + longint'(r.vy));
      nz = clamp24(longint'(chain_z[b]) + longint'(r.vz));
      de = site_energy(b, nx, ny, nz) - site_energy(b, chain_x[b], chain_y[b], chain_z[b]);
      if (de > pmm_pkg::DE_MAX) de = pmm_pkg::DE_MAX;
      if (de < pmm_pkg::DE_MIN) de = pmm_pkg::DE_MIN;
      reject = 1'b0;
      if (de > 0) begin
        ex = 0;
        if (de < (64'sd1 <<< 20)) begin
          ex = 64'd1 << 31;
          for (int k = 0; k < 20; k++)
            if (de[k]) ex = (ex * 64'(EXP_TAB[k])) >> 31;
        end
        reject = ex < (64'(r.draw) << 15);
      end
      if (!reject) begin
        chain_x[b] = nx;
        chain_y[b] = ny;
        chain_z[b] = nz;
        o.acc = 1'b1;
      end
    end
    o.de = de[39:0];
    o.px = chain_x[b];
    o.py = chain_y[b];
    o.pz = chain_z[b];
    return o;
  endfunction

  // Driver: hold valid and payload until accepted, then advance or idle.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 29)) begin
          move_req_t r;
          r = pending_items.pop_front();
          expected_results.push_back(apply_move(r));
          in_valid <= 1'b1;
          mode <= r.mode;
          bead_index <= r.idx;
          x_value <= r.vx;
          y_value <= r.vy;
          z_value <= r.vz;
          uniform_draw <= r.draw;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  // Monitor: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        move_rsp_t e;
        e = expected_results.pop_front();
        if (accepted !== e.acc || delta_energy !== e.de || pos_x !== e.px ||
            pos_y !== e.py || pos_z !== e.pz) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp acc=%0d dE=%0d pos=%0d,%0d,%0d",
                      " got acc=%0d dE=%0d pos=%0d,%0d,%0d"},
                     e.acc, e.de, e.px, e.py, e.pz,
                     accepted, delta_energy, pos_x, pos_y, pos_z);
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  function automatic move_req_t mk(logic [1:0] m, int i, int x, int y, int z, int d);
    move_req_t r;
    r.mode = m;
    r.idx = 5'(i);
    r.vx = pmm_pkg::coord_t'(x);
    r.vy = pmm_pkg::coord_t'(y);
    r.vz = pmm_pkg::coord_t'(z);
    r.draw = 16'(d);
    return r;
  endfunction

  function automatic pmm_pkg::coord_t rnd_small();
    return pmm_pkg::coord_t'(int'($urandom_range(131072)) - 65536);
  endfunction

  // Random item: mostly moves of modest size, some loads/reads, rare wild values.
  function automatic move_req_t rnd_item();
    move_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.idx = 5'($urandom);
    r.draw = 16'($urandom);
    if (pick < 60) begin
      r.mode = pmm_pkg::MODE_MOVE;
      r.vx = rnd_small();
      r.vy = rnd_small();
      r.vz = rnd_small();
    end else if (pick < 75) begin
      r.mode = pmm_pkg::MODE_LOAD;
      r.vx = pmm_pkg::coord_t'(rnd_small() * 2);
      r.vy = pmm_pkg::coord_t'(rnd_small() * 2);
      r.vz = pmm_pkg::coord_t'(int'(r.idx) * 65536) + rnd_small();
    end else if (pick < 85) begin
      r.mode = pmm_pkg::MODE_READ;
      r.vx = pmm_pkg::coord_t'($urandom);
      r.vy = pmm_pkg::coord_t'($urandom);
      r.vz = pmm_pkg::coord_t'($urandom);
    end else begin
      r.mode = 2'($urandom);
      r.vx = pmm_pkg::coord_t'($urandom);
      r.vy = pmm_pkg::coord_t'($urandom);
      r.vz = pmm_pkg::coord_t'($urandom);
    end
    return r;
  endfunction

  // Write a register while idle; mirror it in the predictor.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pmm_pkg::CFG_K:     k_q = 64'(val);
      pmm_pkg::CFG_REST:  rest_q = 64'(val);
      pmm_pkg::CFG_SIGMA: sigma_q = 64'(val);
      default:            eps_q = 64'(val);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until the unit has drained, plus a settle margin.
  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rnd_item());
  endtask

  initial begin
    for (int i = 0; i < NBEAD; i++) begin
      chain_x[i] = '0;
      chain_y[i] = '0;
      chain_z[i] = clamp24(longint'(i) * 65536);
    end
    k_q = 64'd655360;
    rest_q = 64'd65536;
    sigma_q = 64'd65536;
    eps_q = 64'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads of reset state, extreme loads, saturating moves, all modes.
    pending_items.push_back(mk(pmm_pkg::MODE_READ, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(pmm_pkg::MODE_READ, 31, -1, -1, -1, 65535));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 5, 0, 0, 0, 0));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 5, 65536, 0, 0, 65535));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 6, 0, 0, 32768, 0));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 0, 0, 0, 65536, 1));
    pending_items.push_back(mk(pmm_pkg::MODE_LOAD, 31, 8388607, -8388608, 8388607, 0));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 31, 8388607, -8388608, 8388607, 65535));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 31, -8388608, 8388607, -8388608, 0));
    pending_items.push_back(mk(3, 4, 100, 200, 300, 400));
    pending_items.push_back(mk(pmm_pkg::MODE_LOAD, 10, 0, 0, 10 * 65536, 0));
    pending_items.push_back(mk(pmm_pkg::MODE_LOAD, 12, 0, 0, 10 * 65536, 0));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 20, 0, 0, -65536 * 9, 65535));
    pending_items.push_back(mk(pmm_pkg::MODE_READ, 20, 0, 0, 0, 0));
    drain();

    // Repulsion on; coincident beads hit the cap.
    write_reg(pmm_pkg::CFG_EPS, 24'd65536);
    write_reg(pmm_pkg::CFG_SIGMA, 24'd65536);
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 12, 0, 0, 0, 32768));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 3, 0, 0, 65536 * 2, 0));
    pending_items.push_back(mk(pmm_pkg::MODE_MOVE, 8, 20000, -20000, 0, 100));
    run_random(N_RANDOM / 4);
    drain();

    // Extremes of every register.
    write_reg(pmm_pkg::CFG_K, 24'hFFFFFF);
    write_reg(pmm_pkg::CFG_REST, 24'd0);
    write_reg(pmm_pkg::CFG_SIGMA, 24'hFFFFFF);
    write_reg(pmm_pkg::CFG_EPS, 24'hFFFFFF);
    run_random(N_RANDOM / 4);
    drain();

    write_reg(pmm_pkg::CFG_K, 24'd0);
    write_reg(pmm_pkg::CFG_REST, 24'hFFFFFF);
    write_reg(pmm_pkg::CFG_SIGMA, 24'd1);
    write_reg(pmm_pkg::CFG_EPS, 24'd0);
    run_random(N_RANDOM / 8);
    drain();

    // Mild settings with no idling on either side.
    write_reg(pmm_pkg::CFG_K, 24'd65536);
    write_reg(pmm_pkg::CFG_REST, 24'd65536);
    write_reg(pmm_pkg::CFG_SIGMA, 24'd49152);
    write_reg(pmm_pkg::CFG_EPS, 24'd16384);
    no_idle = 1'b1;
    run_random(N_RANDOM / 8);
    drain();
    no_idle = 1'b0;
    run_random(N_RANDOM - 3 * (N_RANDOM / 8) - 2 * (N_RANDOM / 4));
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pmm_pkg.sv
rtl/pmm_bead_cell.sv
rtl/pmm_energy_unit.sv
rtl/pmm_exp_unit.sv
rtl/polymer_metropolis_move_unit.sv
tb/sv/polymer_metropolis_move_unit_tb.sv
